@@ design/rls_pkg.sv @@
// Shared types and constants for the RGB Laplacian sharpen block.
// No dependencies; rls_lane, rls_merge and the top level refer to this package by scoped names.
package rls_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CHAN_W       = 8;
	localparam int NUM_LANES    = 3;
	localparam int NUM_NBR      = 8;

	typedef logic [WIDTH_REG_W-1:0]  wreg_t;
	typedef logic [HEIGHT_REG_W-1:0] hreg_t;
	typedef logic [CHAN_W-1:0]       chan_t;

	localparam wreg_t WIDTH_RESET  = wreg_t'(640);
	localparam hreg_t HEIGHT_RESET = hreg_t'(480);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		chan_t pixel_red;
		chan_t pixel_green;
		chan_t pixel_blue;
		logic  drain;
	} pix_t;

	typedef struct packed {
		chan_t out_red;
		chan_t out_green;
		chan_t out_blue;
		logic  frame_end;
	} res_t;

	// red in the low byte, lane k works on bits [8k +: 8]
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} rgb_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic last;
	} ctl_t;

endpackage

@@ design/rls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rls_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/rls_lane.sv @@
// One color channel of the sharpen filter: neighbor sum, then clamp and saturate.
// Depends on rls_pkg.
module rls_lane (
	input  logic           clk,
	input  logic           en,
	input  logic           border,
	input  rls_pkg::chan_t center,
	input  rls_pkg::chan_t nbr [rls_pkg::NUM_NBR],
	output rls_pkg::chan_t result
);

	logic [10:0]    sum_s3;
	logic [10:0]    sum_c;
	rls_pkg::chan_t c_s3;
	logic           border_s3;
	logic signed [11:0] lap;
	rls_pkg::chan_t lap_clamp;
	logic [8:0]     total;
	logic [8:0]     pick;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < rls_pkg::NUM_NBR; i++) begin
			sum_c = sum_c + {3'b000, nbr[i]};
		end
	end

	always_comb begin
		lap = $signed({1'b0, c_s3, 3'b000}) - $signed({1'b0, sum_s3});
		if (lap < 0) begin
			lap_clamp = '0;
		end else if (lap > 12'sd255) begin
			lap_clamp = 8'hFF;
		end else begin
			lap_clamp = lap[7:0];
		end
		total = {1'b0, c_s3} + {1'b0, lap_clamp};
		pick  = border_s3 ? {c_s3, 1'b0} : total;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3    <= sum_c;
			c_s3      <= center;
			border_s3 <= border;
			result    <= pick[8] ? 8'hFF : pick[7:0];
		end
	end

endmodule

@@ design/rls_merge.sv @@
// Merges the three lane results into one output transaction behind a skid register.
// Depends on rls_pkg.
module rls_merge (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  rls_pkg::chan_t lane_res [rls_pkg::NUM_LANES],
	input  logic           frame_end,
	output logic           room,
	output logic           res_valid,
	input  logic           res_ready,
	output rls_pkg::res_t  res
);

	rls_pkg::res_t merged;
	rls_pkg::res_t out_q;
	rls_pkg::res_t skid_q;
	logic          out_valid_q;
	logic          skid_valid_q;

	assign merged = '{out_red: lane_res[0], out_green: lane_res[1],
		out_blue: lane_res[2], frame_end: frame_end};

	assign room      = !skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!skid_valid_q) begin
			if (!out_valid_q || res_ready) begin
				out_valid_q <= in_valid;
			end else if (in_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (res_ready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			if (!out_valid_q || res_ready) begin
				out_q <= merged;
			end else begin
				skid_q <= merged;
			end
		end else if (res_ready) begin
			out_q <= skid_q;
		end
	end

endmodule

@@ design/rgb_laplacian_sharpen_top.sv @@
// Top level of the RGB Laplacian sharpen: counters, line buffers, 3x3 window, lanes.
// Depends on rls_pkg, rls_ram, rls_lane and rls_merge.
//
//   channel | signals                     | moves
//   pixel   | pix_valid, pix_ready, pix   | one raster pixel or drain item
//   result  | res_valid, res_ready, res   | one sharpened pixel
//   config  | wr_en, wr_index, wr_data    | one register write, no handshake
//
// One item per cycle while pix_ready is high. The item that completes a window passes the
// input register, window shift, lane sum, lane result and output register on its way to res.
// No clearing pass after reset; line buffers hold junk until the first two rows fill.
// pix_ready drops only while the skid register holds a second result that res_ready
// has not yet taken; the whole pipeline then holds.
module rgb_laplacian_sharpen_top #(
	parameter int MAX_WIDTH  = rls_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rls_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_ready,
	input  rls_pkg::pix_t                  pix,
	output logic                           res_valid,
	input  logic                           res_ready,
	output rls_pkg::res_t                  res,
	input  logic                           wr_en,
	input  logic [rls_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rls_pkg::CFG_DATA_W-1:0] wr_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 2);

	rls_pkg::wreg_t image_width_q;
	rls_pkg::hreg_t image_height_q;
	logic [CW-1:0]  w_last;
	logic [RW-1:0]  h_last;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [RW-1:0]  crow;
	logic [CW-1:0]  ccol;
	rls_pkg::ctl_t  ctl_a;
	rls_pkg::rgb_t  px_a;
	logic           cfg_hit;
	logic           adv;
	logic           take;

	logic           v_s1;
	rls_pkg::ctl_t  ctl_s1;
	rls_pkg::rgb_t  px_s1;
	logic [CW-1:0]  col_s1;
	rls_pkg::rgb_t  up2;
	rls_pkg::rgb_t  up1;
	rls_pkg::rgb_t  win_q [3][3];

	logic           v_s2;
	logic           v_s3;
	logic           v_s4;
	logic           border_s2;
	logic           last_s2;
	logic           last_s3;
	logic           last_s4;

	rls_pkg::chan_t lane_res [rls_pkg::NUM_LANES];

	always_comb begin
		if (32'(image_width_q) > MAX_WIDTH) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else if (image_width_q < rls_pkg::wreg_t'(3)) begin
			w_last = CW'(2);
		end else begin
			w_last = CW'(image_width_q - rls_pkg::wreg_t'(1));
		end
		if (32'(image_height_q) > MAX_HEIGHT) begin
			h_last = RW'(MAX_HEIGHT - 1);
		end else if (image_height_q < rls_pkg::hreg_t'(3)) begin
			h_last = RW'(2);
		end else begin
			h_last = RW'(image_height_q - rls_pkg::hreg_t'(1));
		end
	end

	assign cfg_hit = wr_en &&
		(wr_index == rls_pkg::REG_IMAGE_WIDTH || wr_index == rls_pkg::REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= rls_pkg::WIDTH_RESET;
			image_height_q <= rls_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				rls_pkg::REG_IMAGE_WIDTH:  image_width_q  <= wr_data[rls_pkg::WIDTH_REG_W-1:0];
				rls_pkg::REG_IMAGE_HEIGHT: image_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// position of the result this item completes
	always_comb begin
		if (col_q == '0) begin
			ctl_a.emit = row_q >= RW'(2);
			crow       = row_q - RW'(2);
			ccol       = w_last;
		end else begin
			ctl_a.emit = row_q != '0;
			crow       = row_q - RW'(1);
			ccol       = col_q - CW'(1);
		end
		ctl_a.border = crow == '0 || crow >= h_last || ccol == '0 || ccol == w_last;
		ctl_a.last   = crow >= h_last && ccol == w_last;
		px_a         = pix.drain ? '0 :
			'{blue: pix.pixel_blue, green: pix.pixel_green, red: pix.pixel_red};
	end

	assign pix_ready = adv;
	assign take      = pix_valid && adv && !(pix.drain && col_q == '0 && row_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (ctl_a.emit && ctl_a.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == w_last) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	rls_ram #(.WIDTH($bits(rls_pkg::rgb_t)), .DEPTH(MAX_WIDTH)) u_older (
		.clk    (clk),
		.wr_en  (v_s1 && adv),
		.wr_addr(col_s1),
		.wr_data(up1),
		.rd_en  (take),
		.rd_addr(col_q),
		.rd_data(up2)
	);

	rls_ram #(.WIDTH($bits(rls_pkg::rgb_t)), .DEPTH(MAX_WIDTH)) u_newer (
		.clk    (clk),
		.wr_en  (v_s1 && adv),
		.wr_addr(col_s1),
		.wr_data(px_s1),
		.rd_en  (take),
		.rd_addr(col_q),
		.rd_data(up1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1 && ctl_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1    <= ctl_a;
			px_s1     <= px_a;
			col_s1    <= col_q;
			border_s2 <= ctl_s1.border;
			last_s2   <= ctl_s1.last;
			last_s3   <= last_s2;
			last_s4   <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (adv && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up2;
			win_q[1][2] <= up1;
			win_q[2][2] <= px_s1;
		end
	end

	for (genvar k = 0; k < rls_pkg::NUM_LANES; k++) begin : g_lane
		rls_pkg::chan_t center;
		rls_pkg::chan_t nbr [rls_pkg::NUM_NBR];

		always_comb begin
			center = win_q[1][1][8*k +: 8];
			nbr[0] = win_q[0][0][8*k +: 8];
			nbr[1] = win_q[0][1][8*k +: 8];
			nbr[2] = win_q[0][2][8*k +: 8];
			nbr[3] = win_q[1][0][8*k +: 8];
			nbr[4] = win_q[1][2][8*k +: 8];
			nbr[5] = win_q[2][0][8*k +: 8];
			nbr[6] = win_q[2][1][8*k +: 8];
			nbr[7] = win_q[2][2][8*k +: 8];
		end

		rls_lane u_lane (
			.clk   (clk),
			.en    (adv),
			.border(border_s2),
			.center(center),
			.nbr   (nbr),
			.result(lane_res[k])
		);
	end

	rls_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.lane_res (lane_res),
		.frame_end(last_s4),
		.room     (adv),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last)
		else $error("column count beyond row width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} <= {1'b0, h_last} + (RW+1)'(2))
		else $error("row count beyond frame flush");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(take && ctl_a.emit && ctl_a.last) |=> (col_q == '0 && row_q == '0))
		else $error("position not cleared after last pixel");

	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && last_s4) |=> res_valid)
		else $error("frame end result lost before output");

endmodule
